// File: hw/rtl/stt_pkg.sv
// Package for the source text tokenizer: token kinds, token record,
// keyword tables and byte classification helpers.
// Depends on nothing; imported by source_text_tokenizer_top and the testbench.
`default_nettype none

package stt_pkg;

    localparam int COUNTER_BITS = 24;
    localparam int FIELD_BITS   = 24;
    localparam int QUEUE_DEPTH  = 4;

    typedef logic [COUNTER_BITS-1:0] t_count;
    typedef logic [FIELD_BITS-1:0]   t_field;

    localparam logic [3:0] K_NL      = 4'd0;
    localparam logic [3:0] K_ID      = 4'd1;
    localparam logic [3:0] K_DISPLAY = 4'd2;
    localparam logic [3:0] K_MANLO   = 4'd3;
    localparam logic [3:0] K_BOOL    = 4'd4;
    localparam logic [3:0] K_INT     = 4'd5;
    localparam logic [3:0] K_FLOAT   = 4'd6;
    localparam logic [3:0] K_STR     = 4'd7;
    localparam logic [3:0] K_EQ      = 4'd8;
    localparam logic [3:0] K_LPAR    = 4'd9;
    localparam logic [3:0] K_RPAR    = 4'd10;
    localparam logic [3:0] K_COMMA   = 4'd11;
    localparam logic [3:0] K_COLON   = 4'd12;
    localparam logic [3:0] K_UNKNOWN = 4'd13;
    localparam logic [3:0] K_EOF     = 4'd14;

    localparam logic [7:0] KW_TEXT [4][8] = '{
        '{"d", "i", "s", "p", "l", "a", "y", 8'h00},
        '{"m", "a", "n", "l", "o", 8'h00, 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN  [4] = '{4'd7, 4'd5, 4'd4, 4'd5};
    localparam logic [3:0] KW_KIND [4] = '{K_DISPLAY, K_MANLO, K_BOOL, K_BOOL};

    typedef struct packed {
        logic [3:0] kind;
        t_field     offset;
        t_field     length;
        t_field     line;
        logic       last;
    } t_token;

    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + t_count'(1);
    endfunction

    function automatic t_field to_field(input t_count v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_BITS-1:0];
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic [3:0] kw_filter(input logic [3:0] mask, input t_count idx,
                                             input logic [7:0] c);
        logic [3:0] res;
        logic [2:0] i3;
        res = 4'd0;
        i3  = idx[2:0];
        if (idx < t_count'(8)) begin
            for (int k = 0; k < 4; k++) begin
                res[k] = mask[k] && ({1'b0, i3} < KW_LEN[k]) && (KW_TEXT[k][i3] == c);
            end
        end
        return res;
    endfunction

    function automatic logic [3:0] symbol_kind(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            "=":     k = K_EQ;
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            ",":     k = K_COMMA;
            ":":     k = K_COLON;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/source_text_tokenizer_top.sv
// Source text tokenizer top level: lexer state, token build and output queue.
// Depends on stt_pkg.
//
// Usage: source bytes enter on the s_axis channel, one byte per beat, with
// s_axis_tuser[0] set on a final beat that carries no byte and marks the end
// of the text. Tokens leave on the m_axis channel as offset, length and line
// in tdata and the kind in tuser; tlast marks the final token caused by one
// input beat. A byte is fully handled in the cycle it is accepted: the lexer
// state and up to two tokens are written into a four-entry output queue.
// Throughput is one byte per cycle while s_axis_tready is high. A byte that
// ends a pending token and also forms one of its own gives two output beats;
// the queue absorbs that, and s_axis_tready drops only while fewer than two
// queue slots are free, which is also what happens when the receiver stalls.
// The end beat flushes any pending token, emits end-of-file and returns the
// lexer to its reset state. Reset empties the queue and sets offset 0,
// line 1, no pending token.
`default_nettype none

module source_text_tokenizer_top
    import stt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire  [0:0]  s_axis_tuser,   // [0] end_of_source
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [23:0] text_offset, [47:24] text_length,
                                        // [71:48] line_number
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_IDENT = 3'd1,
        M_INT   = 3'd2,
        M_FRAC  = 3'd3,
        M_STR   = 3'd4
    } t_mode;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_mode      r_mode, n_mode;
    t_count     r_start, n_start;
    t_count     r_len, n_len;
    t_count     r_pos, n_pos;
    t_count     r_line, n_line;
    logic [3:0] r_kw, n_kw;

    t_token                  r_queue [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]     r_head, r_tail;
    logic [PTR_BITS:0]       r_count, n_count;

    t_token     tok_a, tok_b;
    logic       val_a, val_b;
    logic       accept, pop;
    logic [3:0] flush_kind;
    logic [7:0] c;
    logic       eos;

    assign c      = s_axis_tdata;
    assign eos    = s_axis_tuser[0];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_count <= (PTR_BITS+1)'(QUEUE_DEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {r_queue[r_head].line, r_queue[r_head].length,
                            r_queue[r_head].offset};
    assign m_axis_tuser  = r_queue[r_head].kind;
    assign m_axis_tlast  = r_queue[r_head].last;

    always_comb begin
        flush_kind = K_ID;
        unique case (r_mode)
            M_IDENT: begin
                flush_kind = K_ID;
                for (int k = 3; k >= 0; k--) begin
                    if (r_kw[k] && r_len == t_count'(KW_LEN[k])) begin
                        flush_kind = KW_KIND[k];
                    end
                end
            end
            M_INT:   flush_kind = K_INT;
            M_FRAC:  flush_kind = K_FLOAT;
            M_STR:   flush_kind = K_STR;
            default: flush_kind = K_ID;
        endcase
    end

    always_comb begin
        logic consumed;
        consumed = 1'b0;
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_pos    = r_pos;
        n_line   = r_line;
        n_kw     = r_kw;
        val_a    = 1'b0;
        val_b    = 1'b0;
        tok_a    = '{kind: flush_kind, offset: to_field(r_start), length: to_field(r_len),
                     line: to_field(r_line), last: 1'b0};
        tok_b    = '{kind: K_EOF, offset: to_field(r_pos), length: '0,
                     line: to_field(r_line), last: 1'b1};

        if (eos) begin
            val_a   = (r_mode != M_IDLE);
            val_b   = 1'b1;
            n_mode  = M_IDLE;
            n_start = '0;
            n_len   = '0;
            n_pos   = '0;
            n_line  = t_count'(1);
            n_kw    = '0;
        end else begin
            unique case (r_mode)
                M_STR: begin
                    consumed = 1'b1;
                    if (c == 8'h22) begin
                        val_a = 1'b1;
                    end else begin
                        n_len = sat_inc(r_len);
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        consumed = 1'b1;
                        n_kw     = kw_filter(r_kw, r_len, c);
                        n_len    = sat_inc(r_len);
                    end else begin
                        val_a = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit(c) || c == ".") begin
                        consumed = 1'b1;
                        if (c == ".") begin
                            n_mode = M_FRAC;
                        end
                        n_len = sat_inc(r_len);
                    end else begin
                        val_a = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        consumed = 1'b1;
                        n_len    = sat_inc(r_len);
                    end else begin
                        val_a = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (val_a) begin
                n_mode = M_IDLE;
                n_kw   = '0;
            end

            tok_b.offset = to_field(r_pos);
            tok_b.length = FIELD_BITS'(1);
            if (!consumed) begin
                priority if (c == 8'h0A) begin
                    val_b      = 1'b1;
                    tok_b.kind = K_NL;
                    n_line     = sat_inc(r_line);
                end else if (is_blank(c)) begin
                    val_b = 1'b0;
                end else if (is_alpha(c)) begin
                    n_mode  = M_IDENT;
                    n_start = r_pos;
                    n_len   = t_count'(1);
                    n_kw    = kw_filter(4'hF, '0, c);
                end else if (is_digit(c)) begin
                    n_mode  = M_INT;
                    n_start = r_pos;
                    n_len   = t_count'(1);
                end else if (c == 8'h22) begin
                    n_mode  = M_STR;
                    n_start = sat_inc(r_pos);
                    n_len   = '0;
                end else begin
                    val_b      = 1'b1;
                    tok_b.kind = symbol_kind(c);
                end
            end
            n_pos      = sat_inc(r_pos);
            tok_a.last = !val_b;
        end
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = n_count + (PTR_BITS+1)'(val_a) + (PTR_BITS+1)'(val_b);
        end
        if (pop) begin
            n_count = n_count - (PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_line  <= t_count'(1);
            r_kw    <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_len   <= n_len;
                r_pos   <= n_pos;
                r_line  <= n_line;
                r_kw    <= n_kw;
                r_tail  <= r_tail + PTR_BITS'(val_a) + PTR_BITS'(val_b);
            end
            if (pop) begin
                r_head <= r_head + PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (val_a) begin
                r_queue[r_tail] <= tok_a;
            end
            if (val_b) begin
                r_queue[r_tail + PTR_BITS'(val_a)] <= tok_b;
            end
        end
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking bench for source_text_tokenizer_top: drives source bytes and end beats
// with random gaps, predicts the token stream and checks every output beat.
// Depends on stt_pkg and source_text_tokenizer_top.
module testbench;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    typedef enum logic [2:0] {LX_IDLE, LX_IDENT, LX_INT, LX_FRAC, LX_STR} t_lex_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_src_beat;

    typedef logic [COUNTER_BITS-1:0] t_ctr;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] char_byte
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] end_of_source
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [71:0] m_axis_tdata;           // [23:0] offset, [47:24] length, [71:48] line
    wire  [3:0]  m_axis_tuser;           // [3:0] token_kind
    wire         m_axis_tlast;

    string      kw_word [4] = '{"display", "manlo", "true", "false"};
    logic [3:0] kw_tok  [4] = '{K_DISPLAY, K_MANLO, K_BOOL, K_BOOL};
    logic [7:0] blank_ch [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    string      ident_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string      symbol_set = "=(),:";

    t_lex_mode  lx_mode;
    t_ctr       tok_start;
    t_ctr       tok_len;
    t_ctr       src_pos;
    t_ctr       src_line;
    logic [3:0] kw_hits;
    t_token     tok_buf [2];
    int         tok_cnt;

    t_token     token_expect [$];
    t_src_beat  src_q [$];
    t_src_beat  cur_beat;
    int         total_items = 0;
    int         beats_in = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         tx_gap = 0;
    int         rx_gap = 0;
    logic       tx_calm = 1'b0;
    logic       rx_calm = 1'b0;
    logic       hold_off = 1'b0;

    source_text_tokenizer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_ctr bump(input t_ctr v);
        return &v ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_spacing(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D && c != CH_NEWLINE);
    endfunction

    function automatic logic [3:0] narrow_kw(input logic [3:0] mask, input t_ctr idx,
                                             input logic [7:0] c);
        logic [3:0] res;
        int k;
        res = 4'd0;
        for (k = 0; k < 4; k++) begin
            if (mask[k] && idx < kw_word[k].len() && kw_word[k][idx] == c)
                res[k] = 1'b1;
        end
        return res;
    endfunction

    function automatic int idle_draw(inout logic calm);
        if ($urandom_range(0, 63) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 5));
    endfunction

    task automatic lexer_reset();
        lx_mode   = LX_IDLE;
        tok_start = '0;
        tok_len   = '0;
        src_pos   = '0;
        src_line  = t_ctr'(1);
        kw_hits   = 4'd0;
    endtask

    task automatic add_token(input logic [3:0] kind, input t_ctr off, input t_ctr len);
        t_token t;
        t.kind   = kind;
        t.offset = off;
        t.length = len;
        t.line   = src_line;
        t.last   = 1'b0;
        tok_buf[tok_cnt] = t;
        tok_cnt++;
    endtask

    task automatic close_token();
        logic [3:0] kind;
        logic       found;
        int         k;
        kind  = K_ID;
        found = 1'b0;
        case (lx_mode)
            LX_IDENT: begin
                for (k = 0; k < 4; k++) begin
                    if (!found && kw_hits[k] && tok_len == kw_word[k].len()) begin
                        kind  = kw_tok[k];
                        found = 1'b1;
                    end
                end
            end
            LX_INT:  kind = K_INT;
            LX_FRAC: kind = K_FLOAT;
            LX_STR:  kind = K_STR;
            default: kind = K_ID;
        endcase
        if (lx_mode != LX_IDLE) begin
            add_token(kind, tok_start, tok_len);
            lx_mode = LX_IDLE;
            kw_hits = 4'd0;
        end
    endtask

    task automatic lex_step(input t_src_beat b);
        logic [7:0] c;
        logic [3:0] kind;
        logic       taken;
        int         i;
        tok_cnt = 0;
        c       = b.ch;
        taken   = 1'b0;
        if (b.eos) begin
            close_token();
            add_token(K_EOF, src_pos, '0);
            lexer_reset();
        end else begin
            case (lx_mode)
                LX_STR: begin
                    if (c == CH_QUOTE)
                        close_token();
                    else
                        tok_len = bump(tok_len);
                    taken = 1'b1;
                end
                LX_IDENT: begin
                    if (is_letter(c) || is_numeral(c)) begin
                        kw_hits = narrow_kw(kw_hits, tok_len, c);
                        tok_len = bump(tok_len);
                        taken   = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                LX_INT: begin
                    if (is_numeral(c) || c == CH_DOT) begin
                        if (c == CH_DOT)
                            lx_mode = LX_FRAC;
                        tok_len = bump(tok_len);
                        taken   = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                LX_FRAC: begin
                    if (is_numeral(c)) begin
                        tok_len = bump(tok_len);
                        taken   = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                default: lx_mode = LX_IDLE;
            endcase
            if (!taken) begin
                if (c == CH_NEWLINE) begin
                    add_token(K_NL, src_pos, t_ctr'(1));
                    src_line = bump(src_line);
                end else if (is_spacing(c)) begin
                    kind = K_UNKNOWN;
                end else if (is_letter(c)) begin
                    lx_mode   = LX_IDENT;
                    tok_start = src_pos;
                    tok_len   = t_ctr'(1);
                    kw_hits   = narrow_kw(4'hF, '0, c);
                end else if (is_numeral(c)) begin
                    lx_mode   = LX_INT;
                    tok_start = src_pos;
                    tok_len   = t_ctr'(1);
                end else if (c == CH_QUOTE) begin
                    lx_mode   = LX_STR;
                    tok_start = bump(src_pos);
                    tok_len   = '0;
                end else begin
                    case (c)
                        "=":     kind = K_EQ;
                        "(":     kind = K_LPAR;
                        ")":     kind = K_RPAR;
                        ",":     kind = K_COMMA;
                        ":":     kind = K_COLON;
                        default: kind = K_UNKNOWN;
                    endcase
                    add_token(kind, src_pos, t_ctr'(1));
                end
            end
            src_pos = bump(src_pos);
        end
        if (tok_cnt > 0)
            tok_buf[tok_cnt-1].last = 1'b1;
        for (i = 0; i < tok_cnt; i++)
            token_expect.push_back(tok_buf[i]);
    endtask

    task automatic push_byte(input logic [7:0] c);
        t_src_beat e;
        e.ch  = c;
        e.eos = 1'b0;
        src_q.push_back(e);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_end();
        t_src_beat e;
        e.ch  = 8'($urandom_range(0, 255));
        e.eos = 1'b1;
        src_q.push_back(e);
    endtask

    task automatic add_fragment();
        int    pick;
        int    n;
        int    i;
        int    k;
        string w;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            push_text(kw_word[$urandom_range(0, 3)]);
            if ($urandom_range(0, 3) == 0)
                push_byte(ident_set[$urandom_range(0, 62)]);
        end else if (pick < 20) begin
            k = $urandom_range(0, 3);
            w = kw_word[k];
            n = $urandom_range(1, w.len() - 1);
            for (i = 0; i < n; i++)
                push_byte(w[i]);
        end else if (pick < 32) begin
            push_byte(ident_set[$urandom_range(0, 52)]);
            n = $urandom_range(0, 7);
            for (i = 0; i < n; i++)
                push_byte(ident_set[$urandom_range(0, 62)]);
        end else if (pick < 42) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                push_byte(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 50) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                push_byte(8'("0" + $urandom_range(0, 9)));
            push_byte(CH_DOT);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                push_byte(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0)
                push_byte(CH_DOT);
        end else if (pick < 58) begin
            push_byte(CH_QUOTE);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) begin
                k = $urandom_range(0, 9);
                if (k == 0)
                    c = CH_NEWLINE;
                else if (k == 1)
                    c = 8'($urandom_range(0, 255));
                else
                    c = 8'($urandom_range(8'h20, 8'h7E));
                push_byte(c == CH_QUOTE ? CH_DOT : c);
            end
            if ($urandom_range(0, 5) != 0)
                push_byte(CH_QUOTE);
        end else if (pick < 70) begin
            push_byte(symbol_set[$urandom_range(0, 4)]);
        end else if (pick < 80) begin
            push_byte(blank_ch[$urandom_range(0, 4)]);
        end else if (pick < 88) begin
            push_byte(CH_NEWLINE);
        end else if (pick < 97) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_end();
        end
    endtask

    task automatic check_token();
        t_token got;
        t_token want;
        got.kind   = m_axis_tuser;
        got.offset = m_axis_tdata[23:0];
        got.length = m_axis_tdata[47:24];
        got.line   = m_axis_tdata[71:48];
        got.last   = m_axis_tlast;
        if (token_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected token: kind %0d off %0d len %0d line %0d last %0b",
                         got.kind, got.offset, got.length, got.line, got.last);
        end else begin
            want = token_expect.pop_front();
            if (got.kind !== want.kind || got.offset !== want.offset ||
                got.length !== want.length || got.line !== want.line ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("token mismatch: expected kind %0d off %0d len %0d line %0d %s%0b,%s",
                             want.kind, want.offset, want.length, want.line, "last ",
                             want.last, $sformatf(" got kind %0d off %0d len %0d line %0d last %0b",
                             got.kind, got.offset, got.length, got.line, got.last));
            end
        end
    endtask

    // Source driver: present beats from the pending queue, idle at random between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            lexer_reset();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_step(cur_beat);
                beats_in++;
                tx_gap = idle_draw(tx_calm);
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    cur_beat = src_q.pop_front();
                    s_axis_tdata  <= cur_beat.ch;
                    s_axis_tuser  <= cur_beat.eos;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Token monitor: check each beat and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_token();
                rx_gap = idle_draw(rx_calm);
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Hold the receiver off long enough for the output queue to fill.
    initial begin
        wait (beats_in >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int base;
        push_text("display(7,x):");
        push_byte(CH_NEWLINE);
        push_text("manlo=true");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_text("1.2.");
        push_byte(CH_QUOTE);
        push_byte(CH_NEWLINE);
        push_end();
        base = src_q.size();
        while (src_q.size() - base < RANDOM_ITEMS)
            add_fragment();
        push_end();
        total_items = src_q.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (beats_in < total_items || token_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && token_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/stt_pkg.sv
hw/rtl/source_text_tokenizer_top.sv
test/testbench.sv
